### sv/lzwd_pkg.sv
// ----------------------------------------------------------------------------
// lzwd_pkg
// Shared types and constants for the windowed LZ decompressor.
// ----------------------------------------------------------------------------
package lzwd_pkg;

	localparam int ADDR_MAX_W = 15;
	localparam int COPY_W = 19;
	localparam int ACC_W = 28;
	localparam int CODE_W = 3;
	localparam logic [CODE_W-1:0] CODE_MAX = 3'd5;
	localparam logic [3:0] WIN_BITS_BASE = 4'd10;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_REFUSED = 2'd1,
		ST_IDLE_TICK = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		KIND_ONE = 2'd0,
		KIND_TWO = 2'd1,
		KIND_THREE = 2'd2,
		KIND_FOUR = 2'd3
	} kind_t;

	typedef struct packed {
		logic rd_en;
		logic [ADDR_MAX_W-1:0] raddr;
		logic wr_en;
		logic [ADDR_MAX_W-1:0] waddr;
		logic from_mem;
		logic [7:0] lit_byte;
		logic out_valid;
		logic copy_busy;
		status_t status;
	} op_t;

endpackage

### sv/lzwd_ctrl.sv
// ----------------------------------------------------------------------------
// lzwd_ctrl
// Token parser and window pointers; issues one window operation per transfer.
// ----------------------------------------------------------------------------
module lzwd_ctrl import lzwd_pkg::*; #(
	parameter int AW = 15
) (
	input  logic clk,
	input  logic arst_n,
	input  logic [CODE_W-1:0] window_code,
	input  logic accept,
	input  logic req_type,
	input  logic [7:0] comp_byte,
	input  logic stream_start,
	output op_t op
);

	logic [AW-1:0] wp_q, wp_n, src_q, src_n;
	logic [COPY_W-1:0] copy_q, copy_n;
	logic [ACC_W-1:0] accum_q, accum_n;
	logic [1:0] tbl_q, tbl_n;
	kind_t kind_q, kind_n;
	logic [4:0] lit_q, lit_n;

	logic [CODE_W-1:0] ec;
	logic [3:0] win_bits;
	logic [AW-1:0] mask, wp_m, src_m;
	logic [ACC_W-1:0] accum_sh, mval, idx_raw, iw_mask, len_mask;
	logic match_go;
	kind_t mkind;
	logic [4:0] r;
	logic [3:0] iw;
	logic [COPY_W-1:0] len_base;
	logic [ADDR_MAX_W-1:0] idx;

	always_comb begin
		ec = (window_code > CODE_MAX) ? CODE_MAX : window_code;
		win_bits = WIN_BITS_BASE + {1'b0, ec};
		if (32'(win_bits) >= AW) begin
			mask = '1;
		end else begin
			mask = AW'((17'd1 << win_bits) - 17'd1);
		end
		wp_m = wp_q & mask;
		src_m = src_q & mask;
		accum_sh = {accum_q[ACC_W-9:0], comp_byte};

		wp_n = wp_q;
		src_n = src_q;
		copy_n = copy_q;
		accum_n = accum_q;
		tbl_n = tbl_q;
		kind_n = kind_q;
		lit_n = lit_q;
		match_go = 1'b0;
		mkind = kind_q;
		mval = accum_sh;
		op = '0;
		op.status = ST_OK;

		if (accept) begin
			if (req_type) begin
				if (copy_q != '0) begin
					op.rd_en = 1'b1;
					op.raddr = ADDR_MAX_W'(src_m);
					op.wr_en = 1'b1;
					op.waddr = ADDR_MAX_W'(wp_m);
					op.from_mem = 1'b1;
					op.out_valid = 1'b1;
					src_n = (src_m + AW'(1)) & mask;
					wp_n = (wp_m + AW'(1)) & mask;
					copy_n = copy_q - COPY_W'(1);
				end else begin
					op.status = ST_IDLE_TICK;
				end
			end else if (stream_start) begin
				op.wr_en = 1'b1;
				op.waddr = '0;
				op.lit_byte = comp_byte;
				op.out_valid = 1'b1;
				wp_n = AW'(1) & mask;
				src_n = '0;
				copy_n = '0;
				accum_n = '0;
				tbl_n = '0;
				kind_n = KIND_ONE;
				lit_n = '0;
			end else if (copy_q != '0) begin
				op.status = ST_REFUSED;
			end else if (lit_q != '0) begin
				op.wr_en = 1'b1;
				op.waddr = ADDR_MAX_W'(wp_m);
				op.lit_byte = comp_byte;
				op.out_valid = 1'b1;
				wp_n = (wp_m + AW'(1)) & mask;
				lit_n = lit_q - 5'd1;
			end else if (tbl_q != '0) begin
				tbl_n = tbl_q - 2'd1;
				if (tbl_q == 2'd1) begin
					match_go = 1'b1;
					kind_n = KIND_ONE;
					accum_n = '0;
				end else begin
					accum_n = accum_sh;
				end
			end else if (comp_byte[7:4] == 4'hf) begin
				lit_n = {1'b0, comp_byte[3:0]} + 5'd1;
			end else if (!comp_byte[7]) begin
				match_go = 1'b1;
				mkind = KIND_ONE;
				mval = ACC_W'(comp_byte);
			end else if (comp_byte[7:6] == 2'b10) begin
				kind_n = KIND_TWO;
				accum_n = ACC_W'(comp_byte[5:0]);
				tbl_n = 2'd1;
			end else if (comp_byte[7:5] == 3'b110) begin
				kind_n = KIND_THREE;
				accum_n = ACC_W'(comp_byte[4:0]);
				tbl_n = 2'd2;
			end else begin
				kind_n = KIND_FOUR;
				accum_n = ACC_W'(comp_byte[3:0]);
				tbl_n = 2'd3;
			end
		end

		case (mkind)
			KIND_ONE: begin
				r = 5'd1;
				iw = 4'd6;
				len_base = COPY_W'(2);
			end
			KIND_TWO: begin
				r = 5'd4 - {3'b0, ec[2:1]};
				iw = 4'd10 + {2'b0, ec[2:1]};
				len_base = COPY_W'(3);
			end
			KIND_THREE: begin
				r = 5'd10 - {2'b0, ec};
				iw = win_bits;
				len_base = COPY_W'(4);
			end
			default: begin
				r = 5'd18 - {2'b0, ec};
				iw = win_bits;
				len_base = COPY_W'(5);
			end
		endcase
		idx_raw = mval >> r;
		iw_mask = (ACC_W'(1) << iw) - ACC_W'(1);
		len_mask = (ACC_W'(1) << r) - ACC_W'(1);
		idx = ADDR_MAX_W'(idx_raw & iw_mask);

		if (match_go) begin
			copy_n = COPY_W'(mval & len_mask) + len_base;
			src_n = (wp_m - AW'(idx) - AW'(1)) & mask;
		end

		op.copy_busy = (copy_n != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			src_q <= '0;
			copy_q <= '0;
			accum_q <= '0;
			tbl_q <= '0;
			kind_q <= KIND_ONE;
			lit_q <= '0;
		end else begin
			wp_q <= wp_n;
			src_q <= src_n;
			copy_q <= copy_n;
			accum_q <= accum_n;
			tbl_q <= tbl_n;
			kind_q <= kind_n;
			lit_q <= lit_n;
		end
	end

endmodule

### sv/lzwd_window.sv
// ----------------------------------------------------------------------------
// lzwd_window
// History window memory with read-after-write forwarding and output register.
// ----------------------------------------------------------------------------
module lzwd_window import lzwd_pkg::*; #(
	parameter int WINDOW_DEPTH = 32768,
	parameter int AW = 15
) (
	input  logic clk,
	input  logic arst_n,
	input  logic accept,
	input  op_t op,
	output logic in_ready,
	output logic out_tvalid,
	input  logic out_tready,
	output logic [7:0] out_tdata,
	output logic [3:0] out_tuser
);

	logic [7:0] mem [WINDOW_DEPTH];
	logic [7:0] rd_q;
	logic [7:0] last_q;
	op_t op_s1;
	logic fwd_s1;
	logic valid_s1;
	logic out_v_q;
	logic [7:0] out_data_q;
	logic [3:0] out_user_q;
	logic adv;
	logic fwd;
	logic [7:0] byte_s1;

	always_comb begin
		adv = valid_s1 && (!out_v_q || out_tready);
		in_ready = !valid_s1 || adv;
		fwd = adv && op_s1.wr_en && op.rd_en && (op_s1.waddr == op.raddr);
		if (!op_s1.from_mem) begin
			byte_s1 = op_s1.lit_byte;
		end else if (fwd_s1) begin
			byte_s1 = last_q;
		end else begin
			byte_s1 = rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && op.rd_en) begin
			rd_q <= mem[op.raddr[AW-1:0]];
		end
		if (adv && op_s1.wr_en) begin
			mem[op_s1.waddr[AW-1:0]] <= byte_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1 <= op;
			fwd_s1 <= fwd;
		end
		if (adv) begin
			last_q <= byte_s1;
			out_data_q <= byte_s1;
			out_user_q <= {op_s1.status, op_s1.copy_busy, op_s1.out_valid};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				out_v_q <= 1'b1;
			end else if (out_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign out_tvalid = out_v_q;
	assign out_tdata = out_data_q;
	assign out_tuser = out_user_q;

endmodule

### sv/lz_window_decompressor.sv
// ----------------------------------------------------------------------------
// lz_window_decompressor
// Windowed LZ decompressor with a byte-oriented token format.
//
// The slave channel carries one request per transfer: s_tdata holds the
// compressed byte, s_tuser holds the request kind (compressed byte or copy
// tick) and the stream start flag. Every request gives exactly one result
// on the master channel: the decompressed byte in m_tdata and the valid,
// copy busy and status flags in m_tuser.
// The block takes one request per cycle while s_tready is high. A request
// transfer starts the synchronous read of the history window into the read
// stage, and the result moves on into the output register when that is free.
// A copy byte written in one cycle can be read back by the next tick
// through a forwarding path.
// Write the window_code register through cfg_we only while no request is
// in flight; the block has no check. WINDOW_DEPTH must be a power of two.
// Reset clears the parser, the pointers and the pipeline; the window memory
// itself is not cleared, and the host starts each stream with a start byte.
// When the receiver stalls, the output register holds its result, one more
// request is taken into the read stage, and then s_tready drops.
// ----------------------------------------------------------------------------
module lz_window_decompressor import lzwd_pkg::*; #(
	parameter int WINDOW_DEPTH = 32768
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [CODE_W-1:0] cfg_wdata,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [7:0] s_tdata,  // comp_byte
	input  logic [1:0] s_tuser,  // req_type, stream_start
	output logic m_tvalid,
	input  logic m_tready,
	output logic [7:0] m_tdata,  // out_byte
	output logic [3:0] m_tuser   // out_valid, copy_busy, status[1:0]
);

	localparam int AW = $clog2(WINDOW_DEPTH);

	logic [CODE_W-1:0] window_code_q;
	logic accept;
	logic in_ready;
	op_t op;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_code_q <= '0;
		end else if (cfg_we) begin
			window_code_q <= cfg_wdata;
		end
	end

	assign accept = s_tvalid && in_ready;
	assign s_tready = in_ready;

	lzwd_ctrl #(
		.AW(AW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.window_code(window_code_q),
		.accept(accept),
		.req_type(s_tuser[0]),
		.comp_byte(s_tdata),
		.stream_start(s_tuser[1]),
		.op(op)
	);

	lzwd_window #(
		.WINDOW_DEPTH(WINDOW_DEPTH),
		.AW(AW)
	) u_window (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.op(op),
		.in_ready(in_ready),
		.out_tvalid(m_tvalid),
		.out_tready(m_tready),
		.out_tdata(m_tdata),
		.out_tuser(m_tuser)
	);

endmodule
